@@ rtl/core/gyro_heading_hold_drive_core_macros.svh @@
// Assertion macros for the heading-hold drive core.
// Included by files that carry concurrent checks; expects clock and reset in scope.
`ifndef GYRO_HEADING_HOLD_DRIVE_CORE_MACROS_SVH
`define GYRO_HEADING_HOLD_DRIVE_CORE_MACROS_SVH

// condition that must hold at every edge outside reset
`define GHD_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define GHD_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

@@ rtl/core/ghd_pkg.sv @@
// Shared types, constants and helpers for the heading-hold drive core.
// No dependencies; used by all modules in rtl/core.
package ghd_pkg;

   localparam int unsigned ADDR_W = 5;
   localparam int unsigned DATA_W = 32;

   // register map, one word per register
   typedef enum logic [2:0] {
      REG_SPEED      = 3'd0,
      REG_PCT_A      = 3'd1,
      REG_PCT_B      = 3'd2,
      REG_DEADZONE   = 3'd3,
      REG_GAIN       = 3'd4,
      REG_MAX_CORR   = 3'd5,
      REG_RUN_LENGTH = 3'd6
   } reg_index_type;

   localparam logic [7:0]  RST_SPEED      = 8'd0;
   localparam logic [6:0]  RST_PCT_A      = 7'd70;
   localparam logic [6:0]  RST_PCT_B      = 7'd80;
   localparam logic [14:0] RST_DEADZONE   = 15'd50;
   localparam logic [7:0]  RST_GAIN       = 8'd1;
   localparam logic [7:0]  RST_MAX_CORR   = 8'd30;
   localparam logic [15:0] RST_RUN_LENGTH = 16'd200;

   localparam logic [16:0] TICK_MS = 17'd10;

   // x/131 = (x*DIV131_MUL) >> 31, exact for x < 2^23
   localparam logic [23:0] DIV131_MUL = 24'd16393005;
   // x/100 = (x*DIV100_MUL) >> 22, exact for x < 2^15
   localparam logic [15:0] DIV100_MUL = 16'd41944;

   localparam logic [7:0] DUTY_MAX = 8'd255;

   localparam logic CMD_START = 1'b0;

   typedef enum logic [1:0] {
      KIND_IGNORE = 2'd0,
      KIND_START  = 2'd1,
      KIND_DRIVE  = 2'd2,
      KIND_FINISH = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0]  speed;
      logic [6:0]  pct_a;
      logic [6:0]  pct_b;
      logic [14:0] deadzone;
      logic [7:0]  gain;
      logic [7:0]  max_corr;
      logic [15:0] run_length;
   } cfg_type;

   // second pipeline stage: decision plus first-level products
   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic        neg;
      logic [22:0] corr_prod;
      logic [14:0] base_a_prod;
      logic [14:0] base_b_prod;
   } stage_type;

   function automatic logic [7:0] sat_duty(input logic signed [10:0] v);
      logic [7:0] r;
      if (v < 11'sd0) begin
         r = 8'd0;
      end else if (v > $signed({3'd0, DUTY_MAX})) begin
         r = DUTY_MAX;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

endpackage

@@ rtl/core/ghd_csr.sv @@
// Configuration register file with APB-style access.
// Depends on ghd_pkg.
module ghd_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ghd_pkg::ADDR_W-1:0]  paddr,
   input  logic [ghd_pkg::DATA_W-1:0]  pwdata,
   output logic [ghd_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output ghd_pkg::cfg_type            cfg
);

   ghd_pkg::cfg_type cfg_ff;
   ghd_pkg::cfg_type cfg_in;
   logic             wr_en;
   logic [2:0]       idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && pready;
   assign idx    = paddr[4:2];
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (idx)
            ghd_pkg::REG_SPEED:      cfg_in.speed      = pwdata[7:0];
            ghd_pkg::REG_PCT_A:      cfg_in.pct_a      = pwdata[6:0];
            ghd_pkg::REG_PCT_B:      cfg_in.pct_b      = pwdata[6:0];
            ghd_pkg::REG_DEADZONE:   cfg_in.deadzone   = pwdata[14:0];
            ghd_pkg::REG_GAIN:       cfg_in.gain       = pwdata[7:0];
            ghd_pkg::REG_MAX_CORR:   cfg_in.max_corr   = pwdata[7:0];
            ghd_pkg::REG_RUN_LENGTH: cfg_in.run_length = pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         ghd_pkg::REG_SPEED:      prdata = {24'd0, cfg_ff.speed};
         ghd_pkg::REG_PCT_A:      prdata = {25'd0, cfg_ff.pct_a};
         ghd_pkg::REG_PCT_B:      prdata = {25'd0, cfg_ff.pct_b};
         ghd_pkg::REG_DEADZONE:   prdata = {17'd0, cfg_ff.deadzone};
         ghd_pkg::REG_GAIN:       prdata = {24'd0, cfg_ff.gain};
         ghd_pkg::REG_MAX_CORR:   prdata = {24'd0, cfg_ff.max_corr};
         ghd_pkg::REG_RUN_LENGTH: prdata = {16'd0, cfg_ff.run_length};
         default:                 prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed      <= ghd_pkg::RST_SPEED;
         cfg_ff.pct_a      <= ghd_pkg::RST_PCT_A;
         cfg_ff.pct_b      <= ghd_pkg::RST_PCT_B;
         cfg_ff.deadzone   <= ghd_pkg::RST_DEADZONE;
         cfg_ff.gain       <= ghd_pkg::RST_GAIN;
         cfg_ff.max_corr   <= ghd_pkg::RST_MAX_CORR;
         cfg_ff.run_length <= ghd_pkg::RST_RUN_LENGTH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/core/ghd_front.sv @@
// Input register, run timer state and first-level products.
// Depends on ghd_pkg.
module ghd_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               req_fire,
   input  logic               req_command,
   input  logic signed [15:0] req_gyro_rate,
   input  ghd_pkg::cfg_type   cfg,
   output logic               s1_valid,
   output ghd_pkg::stage_type s2
);

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_cmd_ff;
   logic signed [15:0] s1_rate_ff;

   logic [16:0]        elapsed_ff, elapsed_in;
   logic               active_ff, active_in;

   ghd_pkg::stage_type s2_ff, s2_in;

   logic [15:0]        raw;
   logic [15:0]        mag;
   logic [15:0]        diff;
   logic [23:0]        prod_full;
   logic               over;

   assign s1_valid = s1_valid_ff;
   assign s2       = s2_ff;

   // s1 can fill while the pipe is stalled only if it was empty
   assign s1_valid_in = req_fire || (s1_valid_ff && !advance);

   always_comb begin
      raw       = s1_rate_ff;
      mag       = raw[15] ? (~raw + 16'd1) : raw;
      over      = mag > {1'b0, cfg.deadzone};
      diff      = mag - {1'b0, cfg.deadzone};
      prod_full = {8'd0, diff} * {16'd0, cfg.gain};
   end

   always_comb begin
      elapsed_in = elapsed_ff;
      active_in  = active_ff;
      s2_in.valid       = s1_valid_ff;
      s2_in.kind        = ghd_pkg::KIND_IGNORE;
      s2_in.neg         = raw[15];
      s2_in.corr_prod   = over ? prod_full[22:0] : 23'd0;
      s2_in.base_a_prod = {7'd0, cfg.speed} * {8'd0, cfg.pct_a};
      s2_in.base_b_prod = {7'd0, cfg.speed} * {8'd0, cfg.pct_b};
      if (s1_cmd_ff == ghd_pkg::CMD_START) begin
         s2_in.kind = ghd_pkg::KIND_START;
         elapsed_in = '0;
         active_in  = 1'b1;
      end else if (active_ff) begin
         if (elapsed_ff < {1'b0, cfg.run_length}) begin
            s2_in.kind = ghd_pkg::KIND_DRIVE;
            elapsed_in = elapsed_ff + ghd_pkg::TICK_MS;
         end else begin
            s2_in.kind = ghd_pkg::KIND_FINISH;
            active_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_ff.valid <= 1'b0;
         elapsed_ff  <= '0;
         active_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) begin
            s2_ff.valid <= s2_in.valid;
            if (s1_valid_ff) begin
               elapsed_ff <= elapsed_in;
               active_ff  <= active_in;
            end
         end
      end
      if (req_fire) begin
         s1_cmd_ff  <= req_command;
         s1_rate_ff <= req_gyro_rate;
      end
      if (advance) begin
         s2_ff.kind        <= s2_in.kind;
         s2_ff.neg         <= s2_in.neg;
         s2_ff.corr_prod   <= s2_in.corr_prod;
         s2_ff.base_a_prod <= s2_in.base_a_prod;
         s2_ff.base_b_prod <= s2_in.base_b_prod;
      end
   end

endmodule

@@ rtl/core/ghd_mix.sv @@
// Constant division, correction clamp, duty mix and result register.
// Depends on ghd_pkg.
module ghd_mix (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  ghd_pkg::stage_type s2,
   input  logic [7:0]         max_corr,
   output logic               rsp_valid,
   output logic [7:0]         rsp_duty_a,
   output logic [7:0]         rsp_duty_b,
   output logic               rsp_running,
   output logic               rsp_finished
);

   logic        valid_ff;
   logic [7:0]  duty_a_ff, duty_a_in;
   logic [7:0]  duty_b_ff, duty_b_in;
   logic        running_ff, running_in;
   logic        finished_ff, finished_in;

   logic [46:0]        quot_prod;
   logic [15:0]        quot;
   logic [7:0]         corr_mag;
   logic [30:0]        base_a_full, base_b_full;
   logic [8:0]         base_a, base_b;
   logic signed [10:0] corr_s, sum_a, sum_b;

   always_comb begin
      quot_prod   = {24'd0, s2.corr_prod} * {23'd0, ghd_pkg::DIV131_MUL};
      quot        = quot_prod[46:31];
      corr_mag    = (quot > {8'd0, max_corr}) ? max_corr : quot[7:0];
      base_a_full = {16'd0, s2.base_a_prod} * {15'd0, ghd_pkg::DIV100_MUL};
      base_b_full = {16'd0, s2.base_b_prod} * {15'd0, ghd_pkg::DIV100_MUL};
      base_a      = base_a_full[30:22];
      base_b      = base_b_full[30:22];
      corr_s      = s2.neg ? -$signed({3'd0, corr_mag}) : $signed({3'd0, corr_mag});
      sum_a       = $signed({2'd0, base_a}) + corr_s;
      sum_b       = $signed({2'd0, base_b}) - corr_s;
   end

   always_comb begin
      duty_a_in   = 8'd0;
      duty_b_in   = 8'd0;
      running_in  = 1'b0;
      finished_in = 1'b0;
      case (s2.kind)
         ghd_pkg::KIND_START: begin
            running_in = 1'b1;
         end
         ghd_pkg::KIND_DRIVE: begin
            duty_a_in  = ghd_pkg::sat_duty(sum_a);
            duty_b_in  = ghd_pkg::sat_duty(sum_b);
            running_in = 1'b1;
         end
         ghd_pkg::KIND_FINISH: begin
            finished_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s2.valid;
      end
      if (advance) begin
         duty_a_ff   <= duty_a_in;
         duty_b_ff   <= duty_b_in;
         running_ff  <= running_in;
         finished_ff <= finished_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_duty_a   = duty_a_ff;
   assign rsp_duty_b   = duty_b_ff;
   assign rsp_running  = running_ff;
   assign rsp_finished = finished_ff;

endmodule

@@ rtl/core/gyro_heading_hold_drive_core.sv @@
// Channel    Dir  Handshake                  Payload
// req        in   req_valid / req_ready      req_command, req_gyro_rate
// rsp        out  rsp_valid / rsp_ready      rsp_duty_a, rsp_duty_b, rsp_running, rsp_finished
// csr        in   psel / penable / pready    paddr, pwdata, pwrite, prdata
//
// Three register stages (input, products, result): the req transfer loads the input register
// and the result register drives rsp; one transfer per cycle while rsp is not stalled.
// The run timer updates as an item leaves the input register, so items stay in order.
// A stalled rsp holds the whole pipe; req_ready drops only when the input register is full.
// Reset is synchronous and clears valids, run state and config to defaults.
// Depends on ghd_pkg, ghd_csr, ghd_front, ghd_mix and the core macros header.
`include "gyro_heading_hold_drive_core_macros.svh"

module gyro_heading_hold_drive_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_command,
   input  logic signed [15:0]          req_gyro_rate,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_duty_a,
   output logic [7:0]                  rsp_duty_b,
   output logic                        rsp_running,
   output logic                        rsp_finished,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ghd_pkg::ADDR_W-1:0]  paddr,
   input  logic [ghd_pkg::DATA_W-1:0]  pwdata,
   output logic [ghd_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);

   ghd_pkg::cfg_type   cfg;
   ghd_pkg::stage_type s2;
   logic               advance;
   logic               req_fire;
   logic               s1_valid;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance || !s1_valid;
   assign req_fire  = req_valid && req_ready;

   ghd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ghd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .req_fire      (req_fire),
      .req_command   (req_command),
      .req_gyro_rate (req_gyro_rate),
      .cfg           (cfg),
      .s1_valid      (s1_valid),
      .s2            (s2)
   );

   ghd_mix u_mix (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .s2           (s2),
      .max_corr     (cfg.max_corr),
      .rsp_valid    (rsp_valid),
      .rsp_duty_a   (rsp_duty_a),
      .rsp_duty_b   (rsp_duty_b),
      .rsp_running  (rsp_running),
      .rsp_finished (rsp_finished)
   );

   `GHD_ASSERT_ALWAYS(a_run_fin_excl, !(rsp_valid && rsp_running && rsp_finished), "running and finished both set")
   `GHD_ASSERT_IMPLY(a_idle_duty_zero, rsp_valid && !rsp_running, (rsp_duty_a == 8'd0) && (rsp_duty_b == 8'd0), "nonzero duty outside a run")
   `GHD_ASSERT_IMPLY(a_ready_only_stall, !req_ready, rsp_valid && !rsp_ready && s1_valid, "req_ready low without a stall")

endmodule

@@ tb/gyro_heading_hold_drive_core_checker.sv @@
// Scoreboard for the heading-hold drive core: tracks CSR writes, predicts each result
// from accepted requests and compares it with the rsp transfers. Depends on ghd_pkg.
module gyro_heading_hold_drive_core_checker
   import ghd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                req_command,
   input  logic signed [15:0]  req_gyro_rate,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [7:0]          rsp_duty_a,
   input  logic [7:0]          rsp_duty_b,
   input  logic                rsp_running,
   input  logic                rsp_finished,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic                pready,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output int                  fail_count,
   output int                  pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RATE_DIV = 131;
   localparam int PCT_DIV  = 100;

   typedef struct packed {
      logic [7:0] duty_a;
      logic [7:0] duty_b;
      logic       running;
      logic       finished;
   } drive_out_type;

   cfg_type       setpoints;
   logic [16:0]   run_elapsed;
   logic          run_on;
   drive_out_type duties_due[$];

   initial begin
      fail_count = 0;
      pending    = 0;
   end

   // deadzoned, scaled and clamped yaw correction; truncates toward zero
   function automatic int steer_trim(input logic signed [15:0] rate);
      int r;
      int mag;
      int trim;
      r   = rate;
      mag = (r < 0) ? -r : r;
      if (mag <= int'(setpoints.deadzone)) return 0;
      trim = ((mag - int'(setpoints.deadzone)) * int'(setpoints.gain)) / RATE_DIV;
      if (trim > int'(setpoints.max_corr)) trim = int'(setpoints.max_corr);
      return (r < 0) ? -trim : trim;
   endfunction

   function automatic logic [7:0] clamp_duty(input int v);
      if (v < 0) return 8'd0;
      if (v > int'(DUTY_MAX)) return DUTY_MAX;
      return v[7:0];
   endfunction

   // advances the run state by one request and returns the duties it produces
   function automatic drive_out_type drive_step(input logic cmd, input logic signed [15:0] rate);
      drive_out_type o;
      int base_a;
      int base_b;
      int trim;
      o = '0;
      if (cmd == CMD_START) begin
         run_elapsed = '0;
         run_on      = 1'b1;
         o.running   = 1'b1;
      end else if (run_on) begin
         if (run_elapsed < {1'b0, setpoints.run_length}) begin
            base_a      = int'(setpoints.speed) * int'(setpoints.pct_a) / PCT_DIV;
            base_b      = int'(setpoints.speed) * int'(setpoints.pct_b) / PCT_DIV;
            trim        = steer_trim(rate);
            o.duty_a    = clamp_duty(base_a + trim);
            o.duty_b    = clamp_duty(base_b - trim);
            run_elapsed = run_elapsed + TICK_MS;
            o.running   = 1'b1;
         end else begin
            run_on     = 1'b0;
            o.finished = 1'b1;
         end
      end
      return o;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      drive_out_type want;
      if (reset) begin
         setpoints.speed      = RST_SPEED;
         setpoints.pct_a      = RST_PCT_A;
         setpoints.pct_b      = RST_PCT_B;
         setpoints.deadzone   = RST_DEADZONE;
         setpoints.gain       = RST_GAIN;
         setpoints.max_corr   = RST_MAX_CORR;
         setpoints.run_length = RST_RUN_LENGTH;
         run_elapsed          = '0;
         run_on               = 1'b0;
         duties_due.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_SPEED:      setpoints.speed      = pwdata[7:0];
               REG_PCT_A:      setpoints.pct_a      = pwdata[6:0];
               REG_PCT_B:      setpoints.pct_b      = pwdata[6:0];
               REG_DEADZONE:   setpoints.deadzone   = pwdata[14:0];
               REG_GAIN:       setpoints.gain       = pwdata[7:0];
               REG_MAX_CORR:   setpoints.max_corr   = pwdata[7:0];
               REG_RUN_LENGTH: setpoints.run_length = pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (duties_due.size() == 0) begin
               $error("rsp transfer with no request outstanding");
               fail_count++;
            end else begin
               want = duties_due.pop_front();
               check_field("duty_a", want.duty_a, rsp_duty_a);
               check_field("duty_b", want.duty_b, rsp_duty_b);
               check_field("running", want.running, rsp_running);
               check_field("finished", want.finished, rsp_finished);
            end
         end
         if (req_valid && req_ready)
            duties_due.push_back(drive_step(req_command, req_gyro_rate));
      end
      pending = duties_due.size();
   end

endmodule

@@ tb/gyro_heading_hold_drive_core_tb.sv @@
// Top of the heading-hold drive core testbench: clock, reset, CSR setups, request
// bursts and rsp back-pressure. Depends on ghd_pkg, the core and the checker module.
module gyro_heading_hold_drive_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ghd_pkg::*;

   localparam logic       CMD_TICK        = 1'b1;
   localparam logic [2:0] REG_UNMAPPED    = 3'd7;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         SETTLE_CYCLES   = 10;
   localparam int         ITEMS_PER_SETUP = 250;
   localparam int         RANDOM_SETUPS   = 8;
   localparam int         HOLD_FIRST      = 1500;
   localparam int         HOLD_PERIOD     = 1000;
   localparam int         HOLD_CYCLES     = 400;

   typedef enum logic [1:0] {RSP_FREE, RSP_PATCHY, RSP_SPARSE} rsp_mode_type;

   logic                clock         = 1'b0;
   logic                reset         = 1'b1;
   logic                req_valid     = 1'b0;
   logic                req_ready;
   logic                req_command   = CMD_TICK;
   logic signed [15:0]  req_gyro_rate = '0;
   logic                rsp_valid;
   logic                rsp_ready     = 1'b0;
   logic [7:0]          rsp_duty_a;
   logic [7:0]          rsp_duty_b;
   logic                rsp_running;
   logic                rsp_finished;
   logic                psel          = 1'b0;
   logic                penable       = 1'b0;
   logic                pwrite        = 1'b0;
   logic [ADDR_W-1:0]   paddr         = '0;
   logic [DATA_W-1:0]   pwdata        = '0;
   logic [DATA_W-1:0]   prdata;
   logic                pready;
   int                  fail_count;
   int                  pending;
   int                  quiet_cycles;
   cfg_type             drive_setup;

   gyro_heading_hold_drive_core DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_gyro_rate (req_gyro_rate),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_running   (rsp_running),
      .rsp_finished  (rsp_finished),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   gyro_heading_hold_drive_core_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_gyro_rate (req_gyro_rate),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_duty_a    (rsp_duty_a),
      .rsp_duty_b    (rsp_duty_b),
      .rsp_running   (rsp_running),
      .rsp_finished  (rsp_finished),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .pready        (pready),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // psel and pwrite stay up across back-to-back writes; csr_idle drops them
   task automatic write_csr(input logic [2:0] idx, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
   endtask

   task automatic csr_idle;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setup(input cfg_type s);
      drive_setup = s;
      write_csr(REG_SPEED, DATA_W'(s.speed));
      write_csr(REG_PCT_A, DATA_W'(s.pct_a));
      write_csr(REG_PCT_B, DATA_W'(s.pct_b));
      write_csr(REG_DEADZONE, DATA_W'(s.deadzone));
      write_csr(REG_GAIN, DATA_W'(s.gain));
      write_csr(REG_MAX_CORR, DATA_W'(s.max_corr));
      write_csr(REG_RUN_LENGTH, DATA_W'(s.run_length));
   endtask

   task automatic send_item(input logic cmd, input logic signed [15:0] rate);
      req_valid     <= 1'b1;
      req_command   <= cmd;
      req_gyro_rate <= rate;
      do @(posedge clock); while (!req_ready);
   endtask

   // checker updates pending at the edge, so read it at the falling edge
   task automatic drain_results;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] random_rate(input logic [14:0] dz);
      int mag;
      logic signed [15:0] r;
      case ($urandom_range(0, 3))
         0: r = 16'($urandom);
         1: begin
            // hover around the deadzone edge
            mag = int'(dz) + int'($urandom_range(0, 300)) - 2;
            if (mag < 0) mag = 0;
            if (mag > 32767) mag = 32767;
            r = ($urandom_range(0, 1) == 0) ? 16'(-mag) : 16'(mag);
         end
         2: r = 16'(int'($urandom_range(0, 600)) - 300);
         default: begin
            case ($urandom_range(0, 3))
               0: r = 16'sh7fff;
               1: r = 16'sh8000;
               2: r = '0;
               default: r = 16'(-(int'(dz) + 1));
            endcase
         end
      endcase
      return r;
   endfunction

   function automatic cfg_type random_setup;
      cfg_type s;
      s.speed      = 8'($urandom);
      s.pct_a      = 7'($urandom);
      s.pct_b      = 7'($urandom);
      s.deadzone   = ($urandom_range(0, 5) == 0) ? 15'($urandom) : 15'($urandom_range(0, 800));
      s.gain       = 8'($urandom);
      s.max_corr   = 8'($urandom);
      s.run_length = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 150));
      return s;
   endfunction

   // mostly ticks inside runs, with a start now and then and bursty gaps
   task automatic run_random(input int count);
      int sent;
      int burst;
      int gap;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int k = 0; k < burst && sent < count; k++) begin
            send_item(($urandom_range(0, 9) == 0) ? CMD_START : CMD_TICK,
                      random_rate(drive_setup.deadzone));
            sent++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // rsp side: random stall patterns plus a periodic long hold-off
   initial begin : rsp_side
      int cyc;
      int hold_left;
      int mode_left;
      rsp_mode_type mode;
      cyc       = 0;
      hold_left = 0;
      mode_left = 0;
      mode      = RSP_FREE;
      forever begin
         @(posedge clock);
         if (!reset) cyc++;
         if (mode_left == 0) begin
            mode      = rsp_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(8, 60);
         end else begin
            mode_left--;
         end
         if (cyc == HOLD_FIRST || (cyc > HOLD_FIRST && (cyc - HOLD_FIRST) % HOLD_PERIOD == 0))
            hold_left = HOLD_CYCLES;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RSP_FREE:   rsp_ready <= 1'b1;
               RSP_PATCHY: rsp_ready <= ($urandom_range(0, 1) == 0);
               default:    rsp_ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("gyro_heading_hold_drive_core_tb: errors");
            $finish;
         end
      end
   end

   initial begin
      cfg_type s;
      drive_setup.speed      = RST_SPEED;
      drive_setup.pct_a      = RST_PCT_A;
      drive_setup.pct_b      = RST_PCT_B;
      drive_setup.deadzone   = RST_DEADZONE;
      drive_setup.gain       = RST_GAIN;
      drive_setup.max_corr   = RST_MAX_CORR;
      drive_setup.run_length = RST_RUN_LENGTH;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset defaults: ticks while idle are ignored, then a short run
      send_item(CMD_TICK, 16'sh7fff);
      send_item(CMD_TICK, 16'sh8000);
      send_item(CMD_START, 16'sh8000);
      send_item(CMD_TICK, 16'sh7fff);
      send_item(CMD_TICK, 16'sh8000);
      send_item(CMD_TICK, 16'sd50);
      send_item(CMD_TICK, -16'sd51);
      drain_results;

      // saturating gain, run that ends after two ticks, restart, unmapped write
      s = '{speed: 8'd200, pct_a: 7'd100, pct_b: 7'd50, deadzone: 15'd0, gain: 8'd255,
            max_corr: 8'd255, run_length: 16'd20};
      apply_setup(s);
      write_csr(REG_UNMAPPED, $urandom);
      csr_idle;
      send_item(CMD_START, 16'sd0);
      send_item(CMD_TICK, 16'sh7fff);
      send_item(CMD_TICK, 16'sh8000);
      send_item(CMD_TICK, 16'sd0);
      send_item(CMD_TICK, 16'sd100);
      send_item(CMD_START, 16'sd0);
      send_item(CMD_START, 16'sd0);
      send_item(CMD_TICK, 16'sd1);
      send_item(CMD_TICK, -16'sd1);
      drain_results;

      // zero run length ends on the first tick
      write_csr(REG_RUN_LENGTH, '0);
      csr_idle;
      drive_setup.run_length = '0;
      send_item(CMD_START, 16'sd0);
      send_item(CMD_TICK, 16'sd300);
      send_item(CMD_TICK, -16'sd300);
      drain_results;

      for (int p = 0; p < RANDOM_SETUPS; p++) begin
         if (p == 0)
            s = '{speed: 8'hff, pct_a: 7'h7f, pct_b: 7'h7f, deadzone: 15'h7fff, gain: 8'hff,
                  max_corr: 8'hff, run_length: 16'hffff};
         else if (p == 1)
            s = '0;
         else
            s = random_setup();
         apply_setup(s);
         csr_idle;
         run_random(ITEMS_PER_SETUP);
         drain_results;
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("gyro_heading_hold_drive_core_tb: clean");
      else
         $display("gyro_heading_hold_drive_core_tb: errors");
      $finish;
   end

endmodule
